// ===== hw/rtl/bdq_pkg.sv =====
package bdq_pkg;

	// Item field widths, fixed by the stream layout
	localparam int CMD_W       = 3;
	localparam int VALUE_W     = 32;
	localparam int POS_W       = 6;
	localparam int COUNT_W     = 7;
	localparam int STATUS_W    = 2;
	localparam int IN_TDATA_W  = 40;   // value + position, padded to bytes
	localparam int OUT_TDATA_W = 40;   // value + count, padded to bytes

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_BACK   = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_READ       = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Decoded action for one item
	typedef struct packed {
		logic    wr;
		logic    rd;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    front_inc;
		logic    front_dec;
		status_t status;
	} bdq_op_t;

endpackage

// ===== hw/rtl/bdq_decode.sv =====
module bdq_decode #(
	parameter int DEPTH = 64
) (
	input  logic [bdq_pkg::CMD_W-1:0]  cmd,
	input  logic [bdq_pkg::POS_W-1:0]  pos,
	input  logic [$clog2(DEPTH)-1:0]   front_ptr,
	input  logic [$clog2(DEPTH+1)-1:0] count,
	output bdq_pkg::bdq_op_t           op,
	output logic [$clog2(DEPTH)-1:0]   addr
);
	import bdq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int OW = ((CW > POS_W) ? CW : POS_W) + 1;

	logic          full;
	logic          empty;
	logic [OW-1:0] pos_ext;
	logic [OW-1:0] cnt_ext;
	logic [OW-1:0] cnt_m1_ext;
	logic [OW-1:0] offset;
	logic [OW-1:0] sum;
	logic [OW-1:0] slot;
	logic [CW-1:0] cnt_m1;

	assign full       = (count == CW'(DEPTH));
	assign empty      = (count == '0);
	assign cnt_m1     = count - CW'(1);
	assign pos_ext    = {{(OW-POS_W){1'b0}}, pos};
	assign cnt_ext    = {{(OW-CW){1'b0}}, count};
	assign cnt_m1_ext = {{(OW-CW){1'b0}}, cnt_m1};

	// Offset from the front; wrap once since the front stays below DEPTH and the offset at most DEPTH
	always_comb begin
		case (cmd)
			CMD_PUSH_BACK: offset = cnt_ext;
			CMD_POP_BACK:  offset = cnt_m1_ext;
			default:       offset = pos_ext;
		endcase
		sum  = {{(OW-AW){1'b0}}, front_ptr} + offset;
		slot = (sum >= OW'(DEPTH)) ? (sum - OW'(DEPTH)) : sum;
	end

	always_comb begin
		op = '0;
		op.status = ST_OK;
		addr = slot[AW-1:0];
		unique case (cmd)
			CMD_PUSH_BACK: begin
				if (full) begin
					op.status = ST_FULL;
				end else begin
					op.wr      = 1'b1;
					op.cnt_inc = 1'b1;
				end
			end
			CMD_PUSH_FRONT: begin
				addr = (front_ptr == '0) ? AW'(DEPTH - 1) : (front_ptr - AW'(1));
				if (full) begin
					op.status = ST_FULL;
				end else begin
					op.wr        = 1'b1;
					op.cnt_inc   = 1'b1;
					op.front_dec = 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					op.status = ST_EMPTY;
				end else begin
					op.rd      = 1'b1;
					op.cnt_dec = 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				addr = front_ptr;
				if (empty) begin
					op.status = ST_EMPTY;
				end else begin
					op.rd        = 1'b1;
					op.cnt_dec   = 1'b1;
					op.front_inc = 1'b1;
				end
			end
			CMD_READ: begin
				if (empty) begin
					op.status = ST_EMPTY;
				end else if (pos_ext >= cnt_ext) begin
					op.status = ST_RANGE;
				end else begin
					op.rd = 1'b1;
				end
			end
			default: begin
				op.status = ST_OK;
			end
		endcase
	end

endmodule

// ===== hw/rtl/bounded_deque.sv =====
// Path: each input item passes through stage 1 and then the output register to become a result item.
// Throughput: one item per cycle unless the sink stalls; the single-port store is read or written
// once per item, and front/count update at accept so the next item can follow right behind.
// Reset: front pointer, count and all valid flags clear; store contents are not cleared
// and only entries inside the count are ever read.
module bounded_deque #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [31:0] push_value, [37:32] position, [39:38] zero
	input  logic [bdq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// [2:0] command
	input  logic [bdq_pkg::CMD_W-1:0]        s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [31:0] result_value, [38:32] element_count, [39] zero
	output logic [bdq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// [1:0] status
	output logic [bdq_pkg::STATUS_W-1:0]     m_axis_tuser
);
	import bdq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// Ring state: front slot and element count
	logic [AW-1:0] front_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_next;
	logic [AW-1:0] front_next;

	// Element store, one access per item
	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] wdata;
	logic [DATA_WIDTH-1:0] rdata_s1;

	// Stage 1: waiting on the store read
	logic          valid_s1;
	logic          rd_s1;
	status_t       status_s1;
	logic [CW-1:0] count_s1;

	// Output register
	logic                out_valid_q;
	logic [VALUE_W-1:0]  value_q;
	logic [COUNT_W-1:0]  count_out_q;
	status_t             status_q;

	logic [VALUE_W-1:0]  value_ext;
	logic [COUNT_W-1:0]  count_ext;

	bdq_op_t       op;
	logic [AW-1:0] addr;
	logic          accept;
	logic          advance;

	bdq_decode #(
		.DEPTH(DEPTH)
	) u_decode (
		.cmd       (s_axis_tuser),
		.pos       (s_axis_tdata[VALUE_W +: POS_W]),
		.front_ptr (front_q),
		.count     (count_q),
		.op        (op),
		.addr      (addr)
	);

	// Move stage 1 forward whenever the output register is free or draining
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Fit push data and stored data to the fixed field widths
	generate
		if (DATA_WIDTH >= VALUE_W) begin : g_wide
			assign wdata     = DATA_WIDTH'(s_axis_tdata[VALUE_W-1:0]);
			assign value_ext = rd_s1 ? rdata_s1[VALUE_W-1:0] : '0;
		end else begin : g_narrow
			assign wdata     = s_axis_tdata[DATA_WIDTH-1:0];
			assign value_ext = rd_s1 ? {{(VALUE_W-DATA_WIDTH){1'b0}}, rdata_s1} : '0;
		end
		if (CW >= COUNT_W) begin : g_cnt_trunc
			assign count_ext = count_s1[COUNT_W-1:0];
		end else begin : g_cnt_ext
			assign count_ext = {{(COUNT_W-CW){1'b0}}, count_s1};
		end
	endgenerate

	// Next ring state for the accepted item
	always_comb begin
		count_next = count_q;
		front_next = front_q;
		if (op.cnt_inc) begin
			count_next = count_q + CW'(1);
		end else if (op.cnt_dec) begin
			count_next = count_q - CW'(1);
		end
		if (op.front_dec) begin
			front_next = addr;
		end else if (op.front_inc) begin
			front_next = (front_q == AW'(DEPTH - 1)) ? '0 : (front_q + AW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_next;
			count_q <= count_next;
		end
	end

	// Store: write on push, read on pop or read; never both for one item
	always_ff @(posedge clk) begin
		if (accept && op.wr) begin
			mem[addr] <= wdata;
		end
		if (accept && op.rd) begin
			rdata_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1     <= op.rd;
			status_s1 <= op.status;
			count_s1  <= count_next;
		end
	end

	// Output register: hold while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			value_q     <= value_ext;
			count_out_q <= count_ext;
			status_q    <= status_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W-VALUE_W-COUNT_W){1'b0}}, count_out_q, value_q};
	assign m_axis_tuser  = status_q;

	// The count never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count above depth");

	// Ring state moves only on an accepted item
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q) && $stable(front_q))
		else $error("ring state changed without an item");

	// Never take an item while both stages are full and stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_axis_tready) |-> !accept)
		else $error("item accepted into a stalled pipeline");

	// Failed steps report a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata[VALUE_W-1:0] == '0))
		else $error("error result carries a value");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for bounded_deque.
// A mirror of the deque follows every accepted command and queues the response it should give.
// Responses are checked in order, field by field.
// Traffic runs in this order:
//   - a short directed opener;
//   - four idling phases of random bursts;
//   - within each phase, fill bursts run the queue up to capacity;
//   - mixed bursts, which lean on positional reads, follow;
//   - drain bursts run it down to empty, and mixed bursts follow again.
module testbench;

	import bdq_pkg::*;

	localparam int DEPTH           = 64;
	localparam int POS_MAX         = (1 << POS_W) - 1;
	localparam int CMD_UNUSED_MIN  = CMD_READ + 1;
	localparam int CMD_CODE_MAX    = (1 << CMD_W) - 1;
	localparam int RESET_CYCLES    = 11;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int PHASE_ITEMS     = 300;
	localparam int DRAIN_CYCLES    = 10;
	localparam int LIMIT_CYCLES    = 200000;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] count;
		status_t            status;
	} deque_response_t;

	// Mirror of the deque contents plus the responses still owed by the block
	class deque_mirror;
		logic [VALUE_W-1:0] slots [DEPTH];
		logic [POS_W-1:0]   head;
		logic [COUNT_W-1:0] fill;
		deque_response_t    expected_responses [$];
		int                 error_count;

		function new();
			head        = '0;
			fill        = '0;
			error_count = 0;
		endfunction

		// Apply one accepted command and queue the response it must produce
		function void note_command(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] push_value,
				logic [POS_W-1:0] position);
			deque_response_t rsp;
			logic [POS_W-1:0] slot;
			rsp.value  = '0;
			rsp.status = ST_OK;
			case (cmd)
				CMD_PUSH_BACK: begin
					if (fill == DEPTH)
						rsp.status = ST_FULL;
					else begin
						slot        = head + fill[POS_W-1:0];
						slots[slot] = push_value;
						fill++;
					end
				end
				CMD_PUSH_FRONT: begin
					if (fill == DEPTH)
						rsp.status = ST_FULL;
					else begin
						head--;
						slots[head] = push_value;
						fill++;
					end
				end
				CMD_POP_BACK: begin
					if (fill == 0)
						rsp.status = ST_EMPTY;
					else begin
						fill--;
						slot      = head + fill[POS_W-1:0];
						rsp.value = slots[slot];
					end
				end
				CMD_POP_FRONT: begin
					if (fill == 0)
						rsp.status = ST_EMPTY;
					else begin
						rsp.value = slots[head];
						head++;
						fill--;
					end
				end
				CMD_READ: begin
					if (fill == 0)
						rsp.status = ST_EMPTY;
					else if ({1'b0, position} >= fill)
						rsp.status = ST_RANGE;
					else begin
						slot      = head + position;
						rsp.value = slots[slot];
					end
				end
				default: begin
					// unused codes leave the queue alone
				end
			endcase
			rsp.count = fill;
			expected_responses.push_back(rsp);
		endfunction

		function void fail(string what);
			error_count++;
			$display("%0t: %s", $time, what);
		endfunction

		// Compare one accepted response with the oldest one owed
		function void check_response(logic [VALUE_W-1:0] value, logic [COUNT_W-1:0] count,
				logic [STATUS_W-1:0] status);
			deque_response_t exp;
			if (expected_responses.size() == 0) begin
				fail($sformatf("response with none owed: value %h count %0d status %0d",
					value, count, status));
				return;
			end
			exp = expected_responses.pop_front();
			if (value !== exp.value)
				fail($sformatf("result_value expected %h actual %h", exp.value, value));
			if (count !== exp.count)
				fail($sformatf("element_count expected %0d actual %0d", exp.count, count));
			if (status !== exp.status)
				fail($sformatf("status expected %0d actual %0d", exp.status, status));
		endfunction

		function int owed();
			return expected_responses.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic [CMD_W-1:0]       s_axis_tuser  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0]    m_axis_tuser;

	deque_mirror mirror;
	int          idle_pct  = 0;   // chance per cycle that the sender holds back
	int          stall_pct = 0;   // chance per cycle that the receiver holds back
	bit          hold_req  = 1'b0;
	int          cycle_count = 0;
	int          items_sent  = 0;

	bounded_deque #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (VALUE_W)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Guard against a hung block
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Receiver: random back-pressure; on request, hold off for a long stretch so the
	// block backs up and drops its own tready
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				m_axis_tready <= 1'b1;
			end else
				m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Check every response the block hands over
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			mirror.check_response(m_axis_tdata[VALUE_W-1:0],
				m_axis_tdata[VALUE_W +: COUNT_W], m_axis_tuser);
	end

	// Offer one item, with a random gap ahead of it; return once it is accepted.
	// Called and returns at a rising edge.
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] push_value,
			input logic [POS_W-1:0] position);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_TDATA_W - VALUE_W - POS_W){1'b0}}, position, push_value};
		s_axis_tuser  <= cmd;
		do
			@(posedge clk);
		while (!s_axis_tready);
		mirror.note_command(cmd, push_value, position);
		items_sent++;
	endtask

	// Draw one command with the given push and pop odds; reads take the rest,
	// bar a few unused codes
	task automatic send_random(input int push_pct, input int pop_pct);
		logic [CMD_W-1:0]   cmd;
		logic [VALUE_W-1:0] push_value;
		logic [POS_W-1:0]   position;
		int                 roll;
		int                 kind;
		roll = $urandom_range(99);
		if (roll < 3)
			cmd = CMD_W'($urandom_range(CMD_CODE_MAX, CMD_UNUSED_MIN));
		else if (roll < 3 + push_pct)
			cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
		else if (roll < 3 + push_pct + pop_pct)
			cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
		else
			cmd = CMD_READ;
		// lean on the all-zero and all-one values now and then
		kind = $urandom_range(9);
		if (kind == 0)
			push_value = '0;
		else if (kind == 1)
			push_value = '1;
		else
			push_value = $urandom;
		// mostly read inside the stored range, sometimes anywhere
		if (mirror.fill != 0 && $urandom_range(99) < 80)
			position = POS_W'($urandom_range(mirror.fill - 1, 0));
		else
			position = POS_W'($urandom_range(POS_MAX, 0));
		send_item(cmd, push_value, position);
	endtask

	// One idling phase: cycle through fill, mixed and drain bursts
	task automatic run_phase(input int sender_idle, input int receiver_stall);
		int start;
		int hits;
		int guard;
		idle_pct  = sender_idle;
		stall_pct = receiver_stall;
		start     = items_sent;
		while (items_sent - start < PHASE_ITEMS) begin
			// fill until full has been hit a few times
			hits  = 0;
			guard = 0;
			while (hits < 6 && guard < 400) begin
				if (mirror.fill == DEPTH)
					hits++;
				send_random(70, 15);
				guard++;
			end
			repeat ($urandom_range(80, 30)) send_random(35, 30);
			// drain until empty has been hit a few times
			hits  = 0;
			guard = 0;
			while (hits < 6 && guard < 400) begin
				if (mirror.fill == 0)
					hits++;
				send_random(15, 70);
				guard++;
			end
			repeat ($urandom_range(80, 30)) send_random(35, 30);
		end
	endtask

	initial begin
		mirror = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opener: empty errors, wrap below slot zero, extremes, range errors,
		// unused codes
		send_item(CMD_POP_BACK, '1, '0);
		send_item(CMD_POP_FRONT, '1, '0);
		send_item(CMD_READ, '0, '0);
		send_item(CMD_READ, '0, '1);
		send_item(CMD_PUSH_BACK, '0, '1);
		send_item(CMD_PUSH_BACK, '1, '0);
		send_item(CMD_PUSH_FRONT, 32'h5A5A_A5A5, '0);
		send_item(CMD_READ, '0, POS_W'(0));
		send_item(CMD_READ, '0, POS_W'(2));
		send_item(CMD_READ, '0, POS_W'(3));
		send_item(CMD_READ, '1, '1);
		send_item(CMD_W'(CMD_UNUSED_MIN), $urandom, POS_W'($urandom));
		send_item(CMD_W'(CMD_UNUSED_MIN + 1), $urandom, POS_W'($urandom));
		send_item(CMD_W'(CMD_CODE_MAX), '1, '1);
		send_item(CMD_POP_FRONT, '0, '0);
		send_item(CMD_POP_BACK, '0, '0);
		send_item(CMD_POP_BACK, '0, '0);
		send_item(CMD_POP_FRONT, '0, '0);
		send_item(CMD_READ, '0, '0);
		send_item(CMD_PUSH_FRONT, 32'h8000_0001, '1);
		send_item(CMD_POP_BACK, '0, '0);

		// Long receiver hold-off while items keep coming, no idling otherwise
		hold_req = 1'b1;
		run_phase(0, 0);
		run_phase(48, 0);
		run_phase(0, 48);
		run_phase(22, 22);

		s_axis_tvalid <= 1'b0;
		stall_pct = 0;
		while (mirror.owed() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mirror.error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_decode.sv
hw/rtl/bounded_deque.sv
tb/sv/testbench.sv
